// ----- hw/rtl/lcdseq_pkg.sv -----
// Shared types, codes and constants of the character LCD write sequencer.
package lcdseq_pkg;

	localparam int CNT_BITS_DEF = 24;
	localparam int REG_BITS     = 24;

	localparam logic [2:0] OP_TICK   = 3'd0;
	localparam logic [2:0] OP_CMD    = 3'd1;
	localparam logic [2:0] OP_CHAR   = 3'd2;
	localparam logic [2:0] OP_CURSOR = 3'd3;
	localparam logic [2:0] OP_CLEAR  = 3'd4;

	localparam logic [2:0] REG_PULSE     = 3'd0;
	localparam logic [2:0] REG_NIB_GAP   = 3'd1;
	localparam logic [2:0] REG_BYTE_GAP  = 3'd2;
	localparam logic [2:0] REG_CLR_EXTRA = 3'd3;
	localparam logic [2:0] REG_POWER_ON  = 3'd4;

	localparam logic [7:0]  PULSE_RST     = 8'd1;
	localparam logic [23:0] NIB_GAP_RST   = 24'd200;
	localparam logic [23:0] BYTE_GAP_RST  = 24'd2000;
	localparam logic [23:0] CLR_EXTRA_RST = 24'd2000;
	localparam logic [23:0] POWER_ON_RST  = 24'd20000;

	localparam logic [7:0] CMD_CLEAR    = 8'h01;
	localparam logic [7:0] ROW0_BASE    = 8'h80;
	localparam logic [7:0] ROW1_BASE    = 8'hC0;
	localparam logic [2:0] INIT_STEPS   = 3'd5;

	typedef enum logic [6:0] {
		PH_POWER    = 7'b0000001,
		PH_HI_EN    = 7'b0000010,
		PH_HI_GAP   = 7'b0000100,
		PH_LO_EN    = 7'b0001000,
		PH_LO_GAP   = 7'b0010000,
		PH_CLR_WAIT = 7'b0100000,
		PH_IDLE     = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic [7:0]  pulse;
		logic [23:0] nib_gap;
		logic [23:0] byte_gap;
		logic [23:0] clr_extra;
		logic [23:0] power_on;
		logic        power_wr;
	} cfg_t;

	typedef struct packed {
		logic [3:0] nibble;
		logic       reg_select;
		logic       enable;
		logic       busy;
		logic       rejected;
	} res_t;

	function automatic logic [7:0] init_byte(input logic [2:0] idx);
		case (idx)
			3'd0:    return 8'h02;
			3'd1:    return 8'h28;
			3'd2:    return 8'h0C;
			3'd3:    return 8'h06;
			default: return CMD_CLEAR;
		endcase
	endfunction

endpackage

// ----- hw/rtl/lcdseq_cfg.sv -----
// Configuration registers of the character LCD write sequencer.
module lcdseq_cfg import lcdseq_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write,
	input  logic [2:0]          cfg_index,
	input  logic [REG_BITS-1:0] cfg_data,
	output cfg_t                cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulse     <= PULSE_RST;
			cfg_q.nib_gap   <= NIB_GAP_RST;
			cfg_q.byte_gap  <= BYTE_GAP_RST;
			cfg_q.clr_extra <= CLR_EXTRA_RST;
			cfg_q.power_on  <= POWER_ON_RST;
			cfg_q.power_wr  <= 1'b0;
		end else begin
			cfg_q.power_wr <= 1'b0;
			if (cfg_write) begin
				unique case (cfg_index)
					REG_PULSE:     cfg_q.pulse     <= cfg_data[7:0];
					REG_NIB_GAP:   cfg_q.nib_gap   <= cfg_data;
					REG_BYTE_GAP:  cfg_q.byte_gap  <= cfg_data;
					REG_CLR_EXTRA: cfg_q.clr_extra <= cfg_data;
					REG_POWER_ON: begin
						cfg_q.power_on <= cfg_data;
						cfg_q.power_wr <= 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hw/rtl/lcdseq_engine.sv -----
// Timing state and per-tick next-state logic of the character LCD write sequencer.
module lcdseq_engine import lcdseq_pkg::*; #(
	parameter int COUNTER_BITS = CNT_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [2:0] op,
	input  logic [7:0] data_byte,
	input  logic [1:0] row,
	input  logic [5:0] column,
	input  cfg_t       cfg,
	output res_t       res
);

	localparam int CB   = COUNTER_BITS;
	localparam int WIDE = (CB > REG_BITS) ? CB : REG_BITS;
	localparam logic [CB-1:0] CNT_MAX = '1;

	typedef struct packed {
		phase_t        phase;
		logic [CB-1:0] cnt;
		logic [7:0]    hb;
		logic          hs;
		logic [2:0]    ii;
		logic          cp;
	} st_t;

	function automatic logic [CB-1:0] sat24(input logic [REG_BITS-1:0] v);
		logic [WIDE-1:0] e;
		e = WIDE'(v);
		if (e > WIDE'(CNT_MAX)) return CNT_MAX;
		return CB'(e);
	endfunction

	function automatic logic [CB-1:0] pulse_cnt(input logic [7:0] p);
		if (p == 8'd0) return CB'(1'b1);
		return CB'(p);
	endfunction

	function automatic st_t load_byte(input st_t s, input logic [7:0] b, input logic sel,
			input logic clr, input cfg_t c);
		st_t r;
		r       = s;
		r.hb    = b;
		r.hs    = sel;
		r.cp    = clr;
		r.phase = PH_HI_EN;
		r.cnt   = pulse_cnt(c.pulse);
		return r;
	endfunction

	function automatic st_t byte_finished(input st_t s, input cfg_t c);
		st_t r;
		r    = s;
		r.cp = 1'b0;
		if (s.ii < INIT_STEPS) begin
			r.ii = s.ii + 3'd1;
			if (r.ii < INIT_STEPS)
				return load_byte(r, init_byte(r.ii), 1'b0, r.ii == INIT_STEPS - 3'd1, c);
		end
		r.phase = PH_IDLE;
		r.cnt   = '0;
		return r;
	endfunction

	function automatic st_t next_phase(input st_t s, input cfg_t c);
		st_t r;
		r = s;
		unique case (s.phase)
			PH_POWER: begin
				r.ii = 3'd0;
				r    = load_byte(r, init_byte(3'd0), 1'b0, 1'b0, c);
			end
			PH_HI_EN: begin
				r.phase = PH_HI_GAP;
				r.cnt   = sat24(c.nib_gap);
			end
			PH_HI_GAP: begin
				r.phase = PH_LO_EN;
				r.cnt   = pulse_cnt(c.pulse);
			end
			PH_LO_EN: begin
				r.phase = PH_LO_GAP;
				r.cnt   = sat24(c.byte_gap);
			end
			PH_LO_GAP: begin
				if (s.cp) begin
					r.phase = PH_CLR_WAIT;
					r.cnt   = sat24(c.clr_extra);
				end else begin
					r = byte_finished(s, c);
				end
			end
			PH_CLR_WAIT: r = byte_finished(s, c);
			default: begin
				r.phase = PH_IDLE;
				r.cnt   = '0;
			end
		endcase
		return r;
	endfunction

	function automatic st_t settle1(input st_t s, input cfg_t c);
		if (s.phase != PH_IDLE && s.cnt == '0) return next_phase(s, c);
		return s;
	endfunction

	st_t st_q;
	st_t st_eff;
	st_t st_set;
	st_t st_ld;
	st_t st_nxt;
	logic req;
	logic rej;

	always_comb begin
		st_eff = st_q;
		if (cfg.power_wr && st_q.phase == PH_POWER)
			st_eff.cnt = sat24(cfg.power_on);

		// Only a power-on wait rewritten to zero can be held at a zero count.
		st_set = settle1(st_eff, cfg);

		req   = (op == OP_CMD) || (op == OP_CHAR) || (op == OP_CURSOR) || (op == OP_CLEAR);
		rej   = req && (st_set.phase != PH_IDLE);
		st_ld = st_set;
		if (req && st_set.phase == PH_IDLE) begin
			case (op)
				OP_CMD:  st_ld = load_byte(st_set, data_byte, 1'b0, 1'b0, cfg);
				OP_CHAR: st_ld = load_byte(st_set, data_byte, 1'b1, 1'b0, cfg);
				OP_CURSOR: begin
					if (row == 2'd0)
						st_ld = load_byte(st_set, ROW0_BASE + {2'b00, column}, 1'b0, 1'b0, cfg);
					else if (row == 2'd1)
						st_ld = load_byte(st_set, ROW1_BASE + {2'b00, column}, 1'b0, 1'b0, cfg);
				end
				OP_CLEAR: st_ld = load_byte(st_set, CMD_CLEAR, 1'b0, 1'b1, cfg);
				default: ;
			endcase
		end

		res.nibble     = (st_ld.phase == PH_HI_EN || st_ld.phase == PH_HI_GAP) ?
			st_ld.hb[7:4] : st_ld.hb[3:0];
		res.reg_select = st_ld.hs;
		res.enable     = (st_ld.phase == PH_HI_EN || st_ld.phase == PH_LO_EN);
		res.busy       = (st_ld.phase != PH_IDLE);
		res.rejected   = rej;

		// Zero-length phases are skipped at once; two further passes cover the longest chain.
		st_nxt = st_ld;
		if (st_ld.phase != PH_IDLE) begin
			st_nxt.cnt = st_ld.cnt - CB'(1'b1);
			if (st_nxt.cnt == '0)
				st_nxt = settle1(settle1(next_phase(st_nxt, cfg), cfg), cfg);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase <= PH_POWER;
			st_q.cnt   <= sat24(POWER_ON_RST);
			st_q.hb    <= 8'd0;
			st_q.hs    <= 1'b0;
			st_q.ii    <= 3'd0;
			st_q.cp    <= 1'b0;
		end else if (step) begin
			st_q <= st_nxt;
		end else begin
			st_q <= st_eff;
		end
	end

endmodule

// ----- hw/rtl/char_lcd_nibble_write_sequencer.sv -----
// Top level of the character LCD write sequencer: request and result registers.
//
// Each accepted request is one timing tick of the LCD bus and yields exactly one
// result holding the pin levels for that tick. One request can be accepted in
// every clock cycle while results are taken; a result is presented once its request
// has passed from the request register into the result register, when that is empty
// or its result is taken, and a new request can enter while an earlier result waits.
// All delays (power-on wait, enable pulse, gaps, clear wait) are counted in
// requests, not in clock cycles. After reset the block waits the power-on time,
// sends the five-byte initialisation sequence and reports busy until it ends;
// requests carrying work while busy are dropped and flagged as rejected.
module char_lcd_nibble_write_sequencer import lcdseq_pkg::*; #(
	parameter int COUNTER_BITS = CNT_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2:0]          op,
	input  logic [7:0]          data_byte,
	input  logic [1:0]          row,
	input  logic [5:0]          column,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [3:0]          bus_nibble,
	output logic                reg_select,
	output logic                enable,
	output logic                busy_res,
	output logic                rejected,
	input  logic                cfg_write,
	input  logic [2:0]          cfg_index,
	input  logic [REG_BITS-1:0] cfg_data
);

	cfg_t       cfg;
	res_t       res;
	logic       valid_s1;
	logic [2:0] op_s1;
	logic [7:0] data_byte_s1;
	logic [1:0] row_s1;
	logic [5:0] column_s1;
	logic       valid_s2;
	res_t       res_s2;
	logic       advance;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	lcdseq_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lcdseq_engine #(
		.COUNTER_BITS (COUNTER_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.op        (op_s1),
		.data_byte (data_byte_s1),
		.row       (row_s1),
		.column    (column_s1),
		.cfg       (cfg),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1        <= op;
			data_byte_s1 <= data_byte;
			row_s1       <= row;
			column_s1    <= column;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid  = valid_s2;
	assign bus_nibble = res_s2.nibble;
	assign reg_select = res_s2.reg_select;
	assign enable     = res_s2.enable;
	assign busy_res   = res_s2.busy;
	assign rejected   = res_s2.rejected;

`ifndef NO_ASSERTIONS
	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rejected |-> busy_res)
		else $error("Rejected request reported while not busy.");

	a_enable_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && enable |-> busy_res)
		else $error("Enable strobe high while not busy.");

	a_stage_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(op_s1) && $stable(data_byte_s1))
		else $error("Stalled request lost from the request register.");

	a_result_written: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("Result register not loaded after a request advanced.");
`endif

endmodule
